### rtl/i2cbm_pkg.sv
// Shared types and constants for the I2C bit-level master.
package i2cbm_pkg;

  localparam logic [15:0] HALF_PERIOD_RESET = 16'd50;
  localparam int unsigned BITS_PER_BYTE = 8;

  typedef enum logic [1:0] {
    MODE_START = 2'd0,
    MODE_WRITE = 2'd1,
    MODE_READ  = 2'd2,
    MODE_STOP  = 2'd3
  } mode_t;

  typedef enum logic [3:0] {
    PH_IDLE = 4'd0,
    PH_ST1  = 4'd1,
    PH_ST2  = 4'd2,
    PH_WD   = 4'd3,
    PH_WH   = 4'd4,
    PH_WAL  = 4'd5,
    PH_WAH  = 4'd6,
    PH_RL   = 4'd7,
    PH_RH   = 4'd8,
    PH_RAL  = 4'd9,
    PH_RAH  = 4'd10,
    PH_SP1  = 4'd11,
    PH_SP2  = 4'd12,
    PH_SP3  = 4'd13
  } phase_t;

  typedef struct packed {
    logic       cmd_valid;
    logic [1:0] mode;
    logic [7:0] write_byte;
    logic       send_ack;
    logic       sda_level;
    logic       scl_level;
  } tick_t;

  typedef struct packed {
    logic       scl_pull_low;
    logic       sda_pull_low;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_byte;
    logic       ack_seen;
    logic       start_error;
  } result_t;

endpackage

### rtl/i2c_bit_level_master_top.sv
// I2C bit-level bus master: each transaction is one tick of the bus timing.
//
// Input channel: in_valid with the tick fields; the block raises in_stall to
// hold a transaction. Each accepted transaction is one bus tick carrying the
// sampled SDA and SCL levels and, optionally, a start, write, read or stop
// command that is taken only while the sequencer is idle.
// Output channel: out_valid with one result per input transaction, holding
// the open-drain pull-low controls, busy, done and the last status values.
// The result is registered after the input register, and one transaction is
// taken every cycle while in_stall is low; the sequencer state advances once per
// tick in a single pass of logic between the input register and the result register.
// A stalled result holds the output register; one more tick waits in the input
// register and in_stall rises only when both are full.
// cfg_we writes half_period_ticks, the ticks per line-change wait.
// Reset releases both lines, returns the sequencer to idle, clears the status
// and sets half_period_ticks to 50.
module i2c_bit_level_master_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        cmd_valid,
  input  logic [1:0]  mode,
  input  logic [7:0]  write_byte,
  input  logic        send_ack,
  input  logic        sda_level,
  input  logic        scl_level,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        scl_pull_low,
  output logic        sda_pull_low,
  output logic        busy_res,
  output logic        done_res,
  output logic [7:0]  read_byte,
  output logic        ack_seen,
  output logic        start_error
);
  import i2cbm_pkg::*;

  tick_t   in_tick;
  tick_t   tick;
  logic    tick_valid;
  logic    advance;
  logic    step;
  result_t res_next;
  result_t res;

  assign in_tick = '{cmd_valid:  cmd_valid,
                     mode:       mode,
                     write_byte: write_byte,
                     send_ack:   send_ack,
                     sda_level:  sda_level,
                     scl_level:  scl_level};

  assign step = tick_valid && advance;

  i2cbm_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_tick    (in_tick),
    .advance    (advance),
    .tick_valid (tick_valid),
    .tick       (tick)
  );

  i2cbm_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .step      (step),
    .tick      (tick),
    .res       (res_next)
  );

  i2cbm_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (tick_valid),
    .res_in    (res_next),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .advance   (advance),
    .res       (res)
  );

  assign scl_pull_low = res.scl_pull_low;
  assign sda_pull_low = res.sda_pull_low;
  assign busy_res     = res.busy_res;
  assign done_res     = res.done_res;
  assign read_byte    = res.read_byte;
  assign ack_seen     = res.ack_seen;
  assign start_error  = res.start_error;

endmodule

### rtl/i2cbm_in_reg.sv
// Input register stage that holds one accepted tick transaction.
module i2cbm_in_reg (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  i2cbm_pkg::tick_t in_tick,
  input  logic             advance,
  output logic             tick_valid,
  output i2cbm_pkg::tick_t tick
);
  import i2cbm_pkg::*;

  assign in_stall = tick_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_valid <= 1'b0;
    end else if (!in_stall) begin
      tick_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      tick <= in_tick;
    end
  end

endmodule

### rtl/i2cbm_core.sv
// Bus sequencer state and the per-tick next-state and result logic.
module i2cbm_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [15:0]        cfg_wdata,
  input  logic               step,
  input  i2cbm_pkg::tick_t   tick,
  output i2cbm_pkg::result_t res
);
  import i2cbm_pkg::*;

  logic [15:0] half_period_ticks;
  phase_t      phase, phase_next;
  logic [3:0]  bit_count, bit_count_next;
  logic [15:0] delay_count, delay_count_next;
  logic [7:0]  shift_byte, shift_byte_next;
  logic        ack_to_send, ack_to_send_next;
  logic [1:0]  pin_drive, pin_drive_next;
  logic [1:0]  status_flags, status_flags_next;
  logic [7:0]  last_read, last_read_next;
  logic        done;
  logic [15:0] reload;

  assign reload = (half_period_ticks == 16'd0) ? 16'd1 : half_period_ticks;

  always_ff @(posedge clk) begin
    if (rst) begin
      half_period_ticks <= HALF_PERIOD_RESET;
    end else if (cfg_we) begin
      half_period_ticks <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      bit_count    <= 4'd0;
      delay_count  <= 16'd0;
      shift_byte   <= 8'd0;
      ack_to_send  <= 1'b0;
      pin_drive    <= 2'b00;
      status_flags <= 2'b00;
      last_read    <= 8'd0;
    end else if (step) begin
      phase        <= phase_next;
      bit_count    <= bit_count_next;
      delay_count  <= delay_count_next;
      shift_byte   <= shift_byte_next;
      ack_to_send  <= ack_to_send_next;
      pin_drive    <= pin_drive_next;
      status_flags <= status_flags_next;
      last_read    <= last_read_next;
    end
  end

  always_comb begin
    phase_next        = phase;
    bit_count_next    = bit_count;
    delay_count_next  = delay_count;
    shift_byte_next   = shift_byte;
    ack_to_send_next  = ack_to_send;
    pin_drive_next    = pin_drive;
    status_flags_next = status_flags;
    last_read_next    = last_read;
    done              = 1'b0;
    if (phase == PH_IDLE) begin
      if (tick.cmd_valid) begin
        bit_count_next   = 4'd0;
        delay_count_next = reload;
        unique case (mode_t'(tick.mode))
          MODE_START: begin
            pin_drive_next = 2'b00;
            phase_next     = PH_ST1;
          end
          MODE_WRITE: begin
            shift_byte_next   = tick.write_byte;
            pin_drive_next[1] = ~tick.write_byte[7];
            phase_next        = PH_WD;
          end
          MODE_READ: begin
            shift_byte_next   = 8'd0;
            ack_to_send_next  = tick.send_ack;
            pin_drive_next[1] = 1'b0;
            phase_next        = PH_RL;
          end
          MODE_STOP: begin
            pin_drive_next[1] = 1'b1;
            phase_next        = PH_SP1;
          end
          default: begin
            phase_next = PH_IDLE;
          end
        endcase
      end
    end else if (delay_count > 16'd1) begin
      delay_count_next = delay_count - 16'd1;
    end else begin
      delay_count_next = 16'd0;
      unique case (phase)
        PH_ST1: begin
          if (!tick.scl_level || !tick.sda_level) begin
            status_flags_next[1] = 1'b1;
            phase_next           = PH_IDLE;
            done                 = 1'b1;
          end else begin
            status_flags_next[1] = 1'b0;
            pin_drive_next[1]    = 1'b1;
            delay_count_next     = reload;
            phase_next           = PH_ST2;
          end
        end
        PH_ST2: begin
          pin_drive_next[0] = 1'b1;
          phase_next        = PH_IDLE;
          done              = 1'b1;
        end
        PH_WD: begin
          pin_drive_next[0] = 1'b0;
          delay_count_next  = reload;
          phase_next        = PH_WH;
        end
        PH_WH: begin
          pin_drive_next[0] = 1'b1;
          bit_count_next    = bit_count + 4'd1;
          shift_byte_next   = {shift_byte[6:0], 1'b0};
          delay_count_next  = reload;
          if (bit_count_next < 4'(BITS_PER_BYTE)) begin
            pin_drive_next[1] = ~shift_byte[6];
            phase_next        = PH_WD;
          end else begin
            pin_drive_next[1] = 1'b0;
            phase_next        = PH_WAL;
          end
        end
        PH_WAL: begin
          pin_drive_next[0] = 1'b0;
          delay_count_next  = reload;
          phase_next        = PH_WAH;
        end
        PH_WAH: begin
          status_flags_next[0] = ~tick.sda_level;
          pin_drive_next[0]    = 1'b1;
          phase_next           = PH_IDLE;
          done                 = 1'b1;
        end
        PH_RL: begin
          pin_drive_next[0] = 1'b0;
          delay_count_next  = reload;
          phase_next        = PH_RH;
        end
        PH_RH: begin
          shift_byte_next   = {shift_byte[6:0], tick.sda_level};
          pin_drive_next[0] = 1'b1;
          bit_count_next    = bit_count + 4'd1;
          delay_count_next  = reload;
          if (bit_count_next < 4'(BITS_PER_BYTE)) begin
            phase_next = PH_RL;
          end else begin
            pin_drive_next[1] = ack_to_send;
            phase_next        = PH_RAL;
          end
        end
        PH_RAL: begin
          pin_drive_next[0] = 1'b0;
          delay_count_next  = reload;
          phase_next        = PH_RAH;
        end
        PH_RAH: begin
          pin_drive_next[0] = 1'b1;
          last_read_next    = shift_byte;
          phase_next        = PH_IDLE;
          done              = 1'b1;
        end
        PH_SP1: begin
          pin_drive_next[0] = 1'b0;
          delay_count_next  = reload;
          phase_next        = PH_SP2;
        end
        PH_SP2: begin
          pin_drive_next[1] = 1'b0;
          delay_count_next  = reload;
          phase_next        = PH_SP3;
        end
        PH_SP3: begin
          phase_next = PH_IDLE;
          done       = 1'b1;
        end
        default: begin
          phase_next = PH_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    res.scl_pull_low = pin_drive_next[0];
    res.sda_pull_low = pin_drive_next[1];
    res.busy_res     = (phase_next != PH_IDLE);
    res.done_res     = done;
    res.read_byte    = last_read_next;
    res.ack_seen     = status_flags_next[0];
    res.start_error  = status_flags_next[1];
  end

endmodule

### rtl/i2cbm_out_reg.sv
// Result register that holds one tick result until the receiver takes it.
module i2cbm_out_reg (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  i2cbm_pkg::result_t res_in,
  input  logic               out_stall,
  output logic               out_valid,
  output logic               advance,
  output i2cbm_pkg::result_t res
);
  import i2cbm_pkg::*;

  assign advance = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && load) begin
      res <= res_in;
    end
  end

endmodule

### test/i2c_bit_level_master_top_tb.sv
// Self-checking testbench for the I2C bit-level master, driven one bus tick per transaction.
module i2c_bit_level_master_top_tb;
  import i2cbm_pkg::*;

  // One bus command as the testbench plays it. data is the byte to write, or the bits the
  // slave returns on a read; ack is send_ack on a read, or the slave's ACK after a write.
  // The x_ fields hold status values typed in by hand, checked on the command's last result when typed is set.
  typedef struct packed {
    logic        set_cfg;
    logic [15:0] half_period;
    logic        cmd;
    mode_t       op;
    logic [7:0]  data;
    logic        ack;
    logic        sda0;
    logic        scl0;
    logic        poke;
    logic        typed;
    logic [7:0]  x_read;
    logic        x_ack;
    logic        x_err;
  } cmd_plan_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [15:0] cfg_wdata;
  logic        in_valid;
  logic        in_stall;
  logic        cmd_valid;
  logic [1:0]  mode;
  logic [7:0]  write_byte;
  logic        send_ack;
  logic        sda_level;
  logic        scl_level;
  logic        out_valid;
  logic        out_stall;
  logic        scl_pull_low;
  logic        sda_pull_low;
  logic        busy_res;
  logic        done_res;
  logic [7:0]  read_byte;
  logic        ack_seen;
  logic        start_error;

  logic [15:0] hp_ticks;
  phase_t      bus_phase;
  logic [3:0]  bit_cnt;
  logic [15:0] wait_cnt;
  logic [7:0]  shreg;
  logic        ack_out;
  logic        scl_low;
  logic        sda_low;
  logic        ack_flag;
  logic        err_flag;
  logic [7:0]  rd_byte;

  result_t bus_results_due [$];
  int      mismatches = 0;
  int      results_taken = 0;
  int      idle_mode = 0;
  bit      long_hold_done = 1'b0;

  cmd_plan_t directed_steps [20] = '{
    '{'0, 16'd0,    '0, MODE_START, 8'h00, '0, '1, '1, '0, '1, 8'h00, '0, '0},
    '{'0, 16'd0,    '1, MODE_START, 8'h00, '0, '1, '0, '0, '1, 8'h00, '0, '1},
    '{'1, 16'd1,    '1, MODE_START, 8'h00, '0, '0, '1, '1, '1, 8'h00, '0, '1},
    '{'0, 16'd0,    '1, MODE_START, 8'h00, '0, '1, '1, '0, '1, 8'h00, '0, '0},
    '{'0, 16'd0,    '1, MODE_WRITE, 8'h00, '1, '1, '1, '0, '1, 8'h00, '1, '0},
    '{'0, 16'd0,    '1, MODE_WRITE, 8'hFF, '0, '1, '1, '0, '1, 8'h00, '0, '0},
    '{'0, 16'd0,    '1, MODE_WRITE, 8'hA5, '1, '1, '1, '1, '0, 8'h00, '0, '0},
    '{'0, 16'd0,    '1, MODE_READ,  8'hFF, '1, '1, '1, '0, '1, 8'hFF, '1, '0},
    '{'0, 16'd0,    '1, MODE_READ,  8'h00, '0, '1, '1, '0, '1, 8'h00, '1, '0},
    '{'0, 16'd0,    '1, MODE_READ,  8'h5A, '1, '1, '1, '1, '0, 8'h00, '0, '0},
    '{'0, 16'd0,    '1, MODE_STOP,  8'h00, '0, '1, '1, '0, '0, 8'h00, '0, '0},
    '{'1, 16'd0,    '1, MODE_START, 8'h00, '0, '1, '1, '0, '0, 8'h00, '0, '0},
    '{'0, 16'd0,    '1, MODE_WRITE, 8'h3C, '0, '1, '1, '0, '0, 8'h00, '0, '0},
    '{'0, 16'd0,    '1, MODE_READ,  8'hC3, '0, '1, '1, '0, '0, 8'h00, '0, '0},
    '{'0, 16'd0,    '1, MODE_STOP,  8'h00, '0, '1, '1, '1, '0, 8'h00, '0, '0},
    '{'1, 16'd2,    '1, MODE_START, 8'h00, '0, '0, '0, '0, '1, 8'hC3, '0, '1},
    '{'0, 16'd0,    '1, MODE_STOP,  8'h00, '0, '1, '1, '0, '0, 8'h00, '0, '0},
    '{'1, 16'd5,    '1, MODE_START, 8'h00, '0, '1, '0, '0, '1, 8'hC3, '0, '1},
    '{'1, 16'd3,    '1, MODE_WRITE, 8'h81, '1, '1, '1, '0, '0, 8'h00, '0, '0},
    '{'0, 16'd0,    '1, MODE_READ,  8'h7E, '1, '1, '1, '1, '0, 8'h00, '0, '0}
  };

  logic [15:0] seg_half_period [6] = '{16'd1, 16'd2, 16'd1, 16'd1, 16'd0, 16'd1};

  i2c_bit_level_master_top uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .cmd_valid    (cmd_valid),
    .mode         (mode),
    .write_byte   (write_byte),
    .send_ack     (send_ack),
    .sda_level    (sda_level),
    .scl_level    (scl_level),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .scl_pull_low (scl_pull_low),
    .sda_pull_low (sda_pull_low),
    .busy_res     (busy_res),
    .done_res     (done_res),
    .read_byte    (read_byte),
    .ack_seen     (ack_seen),
    .start_error  (start_error)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  function automatic void arm_wait(phase_t nxt);
    wait_cnt = (hp_ticks == 16'd0) ? 16'd1 : hp_ticks;
    bus_phase = nxt;
  endfunction

  function automatic result_t step_bus_master(tick_t t);
    result_t r;
    logic fin;
    fin = 1'b0;
    if (bus_phase == PH_IDLE) begin
      if (t.cmd_valid) begin
        bit_cnt = 4'd0;
        case (mode_t'(t.mode))
          MODE_START: begin
            scl_low = 1'b0;
            sda_low = 1'b0;
            arm_wait(PH_ST1);
          end
          MODE_WRITE: begin
            shreg = t.write_byte;
            sda_low = !shreg[7];
            arm_wait(PH_WD);
          end
          MODE_READ: begin
            shreg = 8'd0;
            ack_out = t.send_ack;
            sda_low = 1'b0;
            arm_wait(PH_RL);
          end
          default: begin
            sda_low = 1'b1;
            arm_wait(PH_SP1);
          end
        endcase
      end
    end else if (wait_cnt > 16'd1) begin
      wait_cnt = wait_cnt - 16'd1;
    end else begin
      wait_cnt = 16'd0;
      case (bus_phase)
        PH_ST1: begin
          if (!t.scl_level || !t.sda_level) begin
            err_flag = 1'b1;
            bus_phase = PH_IDLE;
            fin = 1'b1;
          end else begin
            err_flag = 1'b0;
            sda_low = 1'b1;
            arm_wait(PH_ST2);
          end
        end
        PH_ST2: begin
          scl_low = 1'b1;
          bus_phase = PH_IDLE;
          fin = 1'b1;
        end
        PH_WD: begin
          scl_low = 1'b0;
          arm_wait(PH_WH);
        end
        PH_WH: begin
          scl_low = 1'b1;
          bit_cnt = bit_cnt + 4'd1;
          shreg = shreg << 1;
          if (bit_cnt < 4'd8) begin
            sda_low = !shreg[7];
            arm_wait(PH_WD);
          end else begin
            sda_low = 1'b0;
            arm_wait(PH_WAL);
          end
        end
        PH_WAL: begin
          scl_low = 1'b0;
          arm_wait(PH_WAH);
        end
        PH_WAH: begin
          ack_flag = !t.sda_level;
          scl_low = 1'b1;
          bus_phase = PH_IDLE;
          fin = 1'b1;
        end
        PH_RL: begin
          scl_low = 1'b0;
          arm_wait(PH_RH);
        end
        PH_RH: begin
          shreg = {shreg[6:0], t.sda_level};
          scl_low = 1'b1;
          bit_cnt = bit_cnt + 4'd1;
          if (bit_cnt < 4'd8) begin
            arm_wait(PH_RL);
          end else begin
            sda_low = ack_out;
            arm_wait(PH_RAL);
          end
        end
        PH_RAL: begin
          scl_low = 1'b0;
          arm_wait(PH_RAH);
        end
        PH_RAH: begin
          scl_low = 1'b1;
          rd_byte = shreg;
          bus_phase = PH_IDLE;
          fin = 1'b1;
        end
        PH_SP1: begin
          scl_low = 1'b0;
          arm_wait(PH_SP2);
        end
        PH_SP2: begin
          sda_low = 1'b0;
          arm_wait(PH_SP3);
        end
        PH_SP3: begin
          bus_phase = PH_IDLE;
          fin = 1'b1;
        end
        default: begin
          bus_phase = PH_IDLE;
        end
      endcase
    end
    r.scl_pull_low = scl_low;
    r.sda_pull_low = sda_low;
    r.busy_res = (bus_phase != PH_IDLE);
    r.done_res = fin;
    r.read_byte = rd_byte;
    r.ack_seen = ack_flag;
    r.start_error = err_flag;
    return r;
  endfunction

  // Builds the next bus tick: the command while idle, otherwise the slave's answers on the
  // ticks where the master samples and random line levels everywhere else.
  function automatic tick_t make_tick(cmd_plan_t p);
    tick_t t;
    t.cmd_valid = 1'($urandom) & p.poke;
    t.mode = 2'($urandom);
    t.write_byte = 8'($urandom);
    t.send_ack = 1'($urandom);
    t.sda_level = 1'($urandom);
    t.scl_level = 1'($urandom);
    case (bus_phase)
      PH_IDLE: begin
        t.cmd_valid = p.cmd;
        t.mode = p.op;
        if (p.op == MODE_WRITE) t.write_byte = p.data;
        if (p.op == MODE_READ) t.send_ack = p.ack;
      end
      PH_ST1: begin
        t.sda_level = p.sda0;
        t.scl_level = p.scl0;
      end
      PH_RH: t.sda_level = p.data[3'd7 - bit_cnt[2:0]];
      PH_WAH: t.sda_level = !p.ack;
      default: ;
    endcase
    return t;
  endfunction

  task automatic report_mismatch(string msg);
    $display("MISMATCH at result %0d: %s", results_taken, msg);
    mismatches++;
  endtask

  task automatic check_field(string what, logic [7:0] got, logic [7:0] want);
    if (got !== want) report_mismatch($sformatf("%s is %h, expected %h", what, got, want));
  endtask

  task automatic push_tick(tick_t t, cmd_plan_t p);
    result_t want;
    while ($urandom_range(0, 99) < ((idle_mode == 0) ? 12 : (idle_mode == 1) ? 48 : 0)) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    cmd_valid <= t.cmd_valid;
    mode <= t.mode;
    write_byte <= t.write_byte;
    send_ack <= t.send_ack;
    sda_level <= t.sda_level;
    scl_level <= t.scl_level;
    do @(posedge clk); while (in_stall);
    want = step_bus_master(t);
    if (p.typed && (want.done_res || !p.cmd)) begin
      want.read_byte = p.x_read;
      want.ack_seen = p.x_ack;
      want.start_error = p.x_err;
    end
    bus_results_due.push_back(want);
    @(negedge clk);
  endtask

  task automatic run_command(cmd_plan_t p);
    push_tick(make_tick(p), p);
    while (bus_phase != PH_IDLE) push_tick(make_tick(p), p);
  endtask

  task automatic write_half_period(logic [15:0] v);
    in_valid <= 1'b0;
    while (bus_results_due.size() != 0) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    hp_ticks = v;
  endtask

  always @(posedge clk) begin : result_check
    result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (bus_results_due.size() == 0) begin
        report_mismatch("result with no transaction waiting");
      end else begin
        want = bus_results_due.pop_front();
        check_field("scl_pull_low", 8'(scl_pull_low), 8'(want.scl_pull_low));
        check_field("sda_pull_low", 8'(sda_pull_low), 8'(want.sda_pull_low));
        check_field("busy_res", 8'(busy_res), 8'(want.busy_res));
        check_field("done_res", 8'(done_res), 8'(want.done_res));
        check_field("read_byte", read_byte, want.read_byte);
        check_field("ack_seen", 8'(ack_seen), 8'(want.ack_seen));
        check_field("start_error", 8'(start_error), 8'(want.start_error));
      end
      results_taken++;
    end
  end

  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (!long_hold_done && results_taken >= 300) begin
        long_hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (80) @(negedge clk);
      end else begin
        out_stall <= ($urandom_range(0, 99) <
                      ((idle_mode == 0) ? 48 : (idle_mode == 1) ? 12 : 0));
      end
    end
  end

  initial begin
    #12_000_000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    cmd_plan_t p;
    bit bus_open;
    int r;
    int cmds;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = 16'd0;
    in_valid = 1'b0;
    cmd_valid = 1'b0;
    mode = 2'd0;
    write_byte = 8'd0;
    send_ack = 1'b0;
    sda_level = 1'b1;
    scl_level = 1'b1;
    hp_ticks = HALF_PERIOD_RESET;
    bus_phase = PH_IDLE;
    bit_cnt = 4'd0;
    wait_cnt = 16'd0;
    shreg = 8'd0;
    ack_out = 1'b0;
    scl_low = 1'b0;
    sda_low = 1'b0;
    ack_flag = 1'b0;
    err_flag = 1'b0;
    rd_byte = 8'd0;
    bus_open = 1'b0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int i = 0; i < 20; i++) begin
      if (directed_steps[i].set_cfg) write_half_period(directed_steps[i].half_period);
      run_command(directed_steps[i]);
    end

    for (int seg = 0; seg < 6; seg++) begin
      write_half_period(seg_half_period[seg]);
      idle_mode = seg / 2;
      cmds = 0;
      while (cmds < 3) begin
        p = '0;
        if ($urandom_range(0, 3) == 0) run_command(p);
        p.cmd = 1'b1;
        p.poke = ($urandom_range(0, 3) == 0);
        p.data = 8'($urandom);
        p.ack = 1'($urandom);
        p.sda0 = ($urandom_range(0, 9) != 0);
        p.scl0 = ($urandom_range(0, 9) != 0);
        r = $urandom_range(0, 99);
        if (r < 8) p.op = mode_t'($urandom_range(0, 3));
        else if (!bus_open) p.op = MODE_START;
        else if (r < 48) p.op = MODE_WRITE;
        else if (r < 85) p.op = MODE_READ;
        else p.op = MODE_STOP;
        if (p.op == MODE_START) bus_open = p.sda0 && p.scl0;
        if (p.op == MODE_STOP) bus_open = 1'b0;
        run_command(p);
        cmds++;
      end
    end

    in_valid <= 1'b0;
    while (bus_results_due.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
